### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// clock edge and is disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/dts_pkg.sv
`default_nettype none

package dts_pkg;

    // Fixed field widths of the interface.
    localparam int NODE_W = 4;
    localparam int ROW_W  = 16;
    localparam int CNT_W  = 5;
    localparam int MARK_W = 2;

    // Node colors used by the depth-first walk.
    localparam logic [MARK_W-1:0] MARK_WHITE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_GREY  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_BLACK = 2'd2;

    // One input beat: an adjacency row.
    typedef struct packed {
        logic [NODE_W-1:0] row_index;
        logic [ROW_W-1:0]  row_bits;
        logic              last_row;
    } dts_in_t;

    // One result beat.
    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              cyclic;
        logic              last;
    } dts_out_t;

    // One saved level of the walk: the node and the last column taken.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] col;
    } dts_stack_t;

    // Post-order write from the walker into the order buffer.
    typedef struct packed {
        logic              we;
        logic [CNT_W-1:0]  addr;
        logic [NODE_W-1:0] node;
    } dts_order_wr_t;

    // Completion status of one walk.
    typedef struct packed {
        logic             done;
        logic             cyclic;
        logic [CNT_W-1:0] count;
    } dts_walk_stat_t;

endpackage

`default_nettype wire

### hw/rtl/dts_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/dts_walker.sv
`default_nettype none

// Depth-first walk over the stored adjacency rows. The top of the stack is
// cached in registers; lower levels live in the stack RAM.
module dts_walker
    import dts_pkg::*;
#(
    parameter int ROWS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [CNT_W-1:0]        n,
    output logic                         adj_re,
    output logic      [$clog2(ROWS)-1:0] adj_raddr,
    input  wire logic [ROW_W-1:0]        adj_rdata,
    output dts_order_wr_t                order_wr,
    output dts_walk_stat_t               stat
);

    localparam int AW = $clog2(ROWS);

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_ROOT  = 3'd1;
    localparam logic [2:0] W_FETCH = 3'd2;
    localparam logic [2:0] W_SCAN  = 3'd3;
    localparam logic [2:0] W_POP   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [MARK_W-1:0] marks_reg [ROWS];
    logic [MARK_W-1:0] marks_next [ROWS];
    logic [CNT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [NODE_W-1:0] top_node_reg, top_node_next;
    logic [CNT_W-1:0]  top_col_reg, top_col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              done_reg, done_next;
    logic              cyc_reg, cyc_next;

    logic              stk_we;
    logic [AW-1:0]     stk_waddr;
    dts_stack_t        stk_wdata;
    logic              stk_re;
    logic [AW-1:0]     stk_raddr;
    dts_stack_t        stk_rdata;
    logic [NODE_W-1:0] col_j;
    logic [MARK_W-1:0] col_mark;

    // Saved walk levels below the cached top.
    dts_ram #(
        .WIDTH ($bits(dts_stack_t)),
        .DEPTH (ROWS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Column under test and its current color.
    assign col_j    = top_col_reg[NODE_W-1:0];
    assign col_mark = marks_reg[col_j[AW-1:0]];

    // Walk sequencer: one column is examined per cycle, paused while a row or stack read is pending.
    always_comb
    begin
        state_next    = state_reg;
        marks_next    = marks_reg;
        root_next     = root_reg;
        depth_next    = depth_reg;
        count_next    = count_reg;
        top_node_next = top_node_reg;
        top_col_next  = top_col_reg;
        row_next      = row_reg;
        done_next     = 1'b0;
        cyc_next      = cyc_reg;
        adj_re        = 1'b0;
        adj_raddr     = top_node_reg[AW-1:0];
        stk_we        = 1'b0;
        stk_waddr     = AW'(depth_reg - CNT_W'(1));
        stk_wdata     = '{node: top_node_reg, col: col_j};
        stk_re        = 1'b0;
        stk_raddr     = AW'(depth_reg - CNT_W'(2));
        order_wr      = '{we: 1'b0, addr: count_reg, node: top_node_reg};

        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < ROWS; i++)
                    begin
                        marks_next[i] = MARK_WHITE;
                    end
                    root_next  = '0;
                    depth_next = '0;
                    count_next = '0;
                    cyc_next   = 1'b0;
                    state_next = W_ROOT;
                end
            end

            W_ROOT:
            begin
                if (root_reg >= n)
                begin
                    done_next  = 1'b1;
                    state_next = W_IDLE;
                end
                else if (marks_reg[root_reg[AW-1:0]] != MARK_WHITE)
                begin
                    root_next = root_reg + CNT_W'(1);
                end
                else
                begin
                    marks_next[root_reg[AW-1:0]] = MARK_GREY;
                    top_node_next = root_reg[NODE_W-1:0];
                    top_col_next  = '0;
                    depth_next    = CNT_W'(1);
                    adj_re        = 1'b1;
                    adj_raddr     = root_reg[AW-1:0];
                    state_next    = W_FETCH;
                end
            end

            W_FETCH:
            begin
                row_next   = adj_rdata;
                state_next = W_SCAN;
            end

            W_SCAN:
            begin
                if (top_col_reg >= n)
                begin
                    // No more columns: the node is finished.
                    marks_next[top_node_reg[AW-1:0]] = MARK_BLACK;
                    order_wr.we = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    depth_next  = depth_reg - CNT_W'(1);
                    if (depth_reg == CNT_W'(1))
                    begin
                        root_next  = root_reg + CNT_W'(1);
                        state_next = W_ROOT;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        state_next = W_POP;
                    end
                end
                else
                begin
                    top_col_next = top_col_reg + CNT_W'(1);
                    if (row_reg[col_j])
                    begin
                        if (col_mark == MARK_GREY)
                        begin
                            cyc_next   = 1'b1;
                            done_next  = 1'b1;
                            state_next = W_IDLE;
                        end
                        else if (col_mark == MARK_WHITE)
                        begin
                            // Descend: save this level, make the neighbor the top.
                            stk_we = 1'b1;
                            marks_next[col_j[AW-1:0]] = MARK_GREY;
                            top_node_next = col_j;
                            top_col_next  = '0;
                            depth_next    = depth_reg + CNT_W'(1);
                            adj_re        = 1'b1;
                            adj_raddr     = col_j[AW-1:0];
                            state_next    = W_FETCH;
                        end
                    end
                end
            end

            W_POP:
            begin
                // Resume the parent one column past the child it took.
                top_node_next = stk_rdata.node;
                top_col_next  = {1'b0, stk_rdata.col} + CNT_W'(1);
                adj_re        = 1'b1;
                adj_raddr     = stk_rdata.node[AW-1:0];
                state_next    = W_FETCH;
            end

            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Control and mark registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            for (int i = 0; i < ROWS; i++)
            begin
                marks_reg[i] <= MARK_WHITE;
            end
            root_reg  <= '0;
            depth_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            cyc_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            marks_reg  <= marks_next;
            root_reg   <= root_next;
            depth_reg  <= depth_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            cyc_reg    <= cyc_next;
        end
    end

    // Cached top of stack and its row.
    always_ff @(posedge clk)
    begin
        top_node_reg <= top_node_next;
        top_col_reg  <= top_col_next;
        row_reg      <= row_next;
    end

    assign stat = '{done: done_reg, cyclic: cyc_reg, count: count_reg};

endmodule

`default_nettype wire

### hw/rtl/dfs_topological_sort_core.sv
`default_nettype none

// Depth-first topological sort with cycle detection. Rows load at one beat
// per cycle while busy is low; the beat with last_row set stores its row and
// starts the sort, and busy stays high until the cycle that shows the final
// result beat. The walk examines one adjacency column per cycle and pauses
// for each read of the row RAM and of the stack RAM. If no cycle is found,
// the nodes leave in post-order (reverse topological order), one result beat
// per cycle with last on the final one; a cycle gives one beat with cyclic
// and last set and node_index zero. Result beats are shown on result for a
// single cycle, marked by strobe, and must be taken then: there is no way to
// hold them off. Node marks clear in the cycle the sort starts, so no clearing
// pass is needed. Every row used by a sort must have been written
// beforehand.
module dfs_topological_sort_core
    import dts_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dts_in_t          cmd,
    output logic                  strobe,
    output dts_out_t              result,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_data
);

`include "assert_macros.svh"

    localparam int ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int AW   = $clog2(ROWS);
    localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  node_count_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              strobe_reg, strobe_next;
    dts_out_t          result_reg, result_next;

    logic              accept;
    logic              walk_start;
    logic              adj_we;
    logic              adj_re;
    logic [AW-1:0]     adj_raddr;
    logic [ROW_W-1:0]  adj_rdata;
    dts_order_wr_t     order_wr;
    dts_walk_stat_t    walk_stat;
    logic              order_re;
    logic [AW-1:0]     order_raddr;
    logic [NODE_W-1:0] order_rdata;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign walk_start = accept && cmd.last_row;
    assign adj_we     = accept && ({1'b0, cmd.row_index} < ROWS_C);
    assign n_eff      = (node_count_reg > ROWS_C) ? ROWS_C : node_count_reg;

    // Node count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(16);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // Adjacency rows, written only while no walk runs.
    dts_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_adj (
        .clk   (clk),
        .we    (adj_we),
        .waddr (cmd.row_index[AW-1:0]),
        .wdata (cmd.row_bits),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dts_walker #(
        .ROWS (ROWS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .n         (n_eff),
        .adj_re    (adj_re),
        .adj_raddr (adj_raddr),
        .adj_rdata (adj_rdata),
        .order_wr  (order_wr),
        .stat      (walk_stat)
    );

    // Post-order buffer filled by the walker and read one entry ahead.
    dts_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ROWS)
    ) u_order (
        .clk   (clk),
        .we    (order_wr.we),
        .waddr (order_wr.addr[AW-1:0]),
        .wdata (order_wr.node),
        .re    (order_re),
        .raddr (order_raddr),
        .rdata (order_rdata)
    );

    // Run control and result sequencing.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        order_re    = 1'b0;
        order_raddr = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (walk_start)
                begin
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (walk_stat.done)
                begin
                    if (walk_stat.cyclic)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{node_index: '0, cyclic: 1'b1, last: 1'b1};
                        state_next  = S_IDLE;
                    end
                    else if (walk_stat.count == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Fetch the first entry so it is ready in S_EMIT.
                        idx_next    = '0;
                        total_next  = walk_stat.count;
                        order_re    = 1'b1;
                        order_raddr = '0;
                        state_next  = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                strobe_next = 1'b1;
                result_next = '{node_index: order_rdata,
                                cyclic: 1'b0,
                                last: (idx_reg == total_reg - CNT_W'(1))};
                idx_next    = idx_reg + CNT_W'(1);
                order_re    = 1'b1;
                order_raddr = AW'(idx_reg + CNT_W'(1));
                if (idx_reg == total_reg - CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            idx_reg    <= idx_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // A cycle report is a single final beat with a zero node index.
    `ASSERT_SAME(a_cyclic_form, clk, rst_n, strobe && result.cyclic, result.last && (result.node_index == '0), "cyclic beat malformed")

    // Post-order beats leave back to back until the final one.
    `ASSERT_NEXT(a_emit_contig, clk, rst_n, strobe && !result.last, strobe, "gap in result run")

    // A sort start holds off the next item.
    `ASSERT_NEXT(a_start_busy, clk, rst_n, walk_start, busy, "busy not raised after last row")

    // A walk that found a cycle reports it in the following cycle.
    `ASSERT_NEXT(a_cycle_report, clk, rst_n, (state_reg == S_WALK) && walk_stat.done && walk_stat.cyclic, strobe && result.cyclic, "cycle not reported")

endmodule

`default_nettype wire
